// File: hdl/bc_pkg.sv
package bc_pkg;

  localparam int unsigned CountWidth  = 16;
  localparam int unsigned ResultWidth = 64;

  typedef struct packed {
    logic signed [CountWidth-1:0] item_count;
    logic signed [CountWidth-1:0] chosen_count;
  } in_word_t;

  typedef struct packed {
    logic [ResultWidth-1:0] combinations;
    logic                   overflow;
  } out_word_t;

endpackage

// File: hdl/bc_mul_div.sv
module bc_mul_div
  import bc_pkg::*;
#(
  parameter int unsigned CntW = CountWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ResultWidth-1:0] acc_i,
  input  logic [CntW-1:0]        mul_i,
  input  logic [CntW-1:0]        div_i,
  output logic                   done_o,
  output logic [ResultWidth-1:0] quot_o,
  output logic                   ovf_o
);

  localparam int unsigned PW    = ResultWidth + CntW;
  localparam int unsigned CntBw = $clog2(PW);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV
  } md_state_e;

  md_state_e              state_q, state_d;
  logic [CntBw-1:0]       cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic [PW-1:0]          prod_q, prod_d;
  logic [ResultWidth-1:0] mcand_q, mcand_d;
  logic [CntW-1:0]        mplier_q, mplier_d;
  logic [CntW-1:0]        div_q, div_d;
  logic [CntW-1:0]        rem_q, rem_d;
  logic [CntW:0]          trial;
  logic [CntW:0]          diff;
  logic                   qbit;

  // The product is built MSB first by shift and add, then the same register
  // is divided in place by restoring division, one quotient bit per cycle.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    prod_d   = prod_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    div_d    = div_q;
    rem_d    = rem_q;
    trial    = {rem_q, prod_q[PW-1]};
    diff     = trial - {1'b0, div_q};
    qbit     = (trial >= {1'b0, div_q});
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          mcand_d  = acc_i;
          mplier_d = mul_i;
          div_d    = div_i;
          prod_d   = '0;
          rem_d    = '0;
          cnt_d    = '0;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        prod_d   = {prod_q[PW-2:0], 1'b0} +
                   (mplier_q[CntW-1] ? {{CntW{1'b0}}, mcand_q} : {PW{1'b0}});
        mplier_d = {mplier_q[CntW-2:0], 1'b0};
        if (cnt_q == CntBw'(CntW - 1)) begin
          cnt_d   = '0;
          state_d = S_DIV;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DIV: begin
        rem_d  = qbit ? diff[CntW-1:0] : trial[CntW-1:0];
        prod_d = {prod_q[PW-2:0], qbit};
        if (cnt_q == CntBw'(PW - 1)) begin
          cnt_d   = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    div_q    <= div_d;
    rem_q    <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = prod_q[ResultWidth-1:0];
  assign ovf_o  = |prod_q[PW-1:ResultWidth];

endmodule

// File: hdl/binomial_coefficient.sv
// Computes C(n,k) for signed 16-bit n and k as an exact 64-bit integer, one
// word at a time. Negative n or k, or k above n, give 1; a result beyond
// 2^64-1 gives all ones with overflow set. The work is m = min(k, n-k)
// multiply-then-divide steps on one bit-serial unit; each step is issued,
// runs shift-and-add and then restoring division, and returns its quotient.
// Overflow ends the loop early, so no word runs more than 33 steps.
// A new word is taken while the previous result still waits in the
// output register.
module binomial_coefficient
  import bc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ISSUE,
    S_WAIT,
    S_FINISH
  } state_e;

  state_e                       state_q, state_d;
  logic                         out_valid_q, out_valid_d;
  out_word_t                    out_q, out_d;
  logic signed [CountWidth-1:0] n_q, n_d;
  logic signed [CountWidth-1:0] k_q, k_d;
  logic [CountWidth-1:0]        m_q, m_d;
  logic [CountWidth-1:0]        i_q, i_d;
  logic [ResultWidth-1:0]       acc_q, acc_d;
  logic                         ovf_q, ovf_d;
  logic                         invalid;
  logic [CountWidth-1:0]        n_minus_k;
  logic                         start;
  logic                         md_done;
  logic [ResultWidth-1:0]       md_quot;
  logic                         md_ovf;

  assign invalid   = (n_q < 0) || (k_q < 0) || (k_q > n_q);
  assign n_minus_k = n_q - k_q;
  assign start     = (state_q == S_ISSUE) && (i_q != m_q);

  bc_mul_div #(
    .CntW(CountWidth)
  ) u_mul_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .acc_i  (acc_q),
    .mul_i  (n_q - i_q),
    .div_i  (i_q + 1'b1),
    .done_o (md_done),
    .quot_o (md_quot),
    .ovf_o  (md_ovf)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    n_d         = n_q;
    k_d         = k_q;
    m_d         = m_q;
    i_d         = i_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          n_d     = in_word_i.item_count;
          k_d     = in_word_i.chosen_count;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        acc_d = ResultWidth'(1);
        ovf_d = 1'b0;
        i_d   = '0;
        m_d   = (unsigned'(k_q) < n_minus_k) ? unsigned'(k_q) : n_minus_k;
        state_d = invalid ? S_FINISH : S_ISSUE;
      end
      S_ISSUE: begin
        state_d = (i_q == m_q) ? S_FINISH : S_WAIT;
      end
      S_WAIT: begin
        if (md_done) begin
          if (md_ovf) begin
            acc_d   = '1;
            ovf_d   = 1'b1;
            state_d = S_FINISH;
          end else begin
            acc_d   = md_quot;
            i_d     = i_q + 1'b1;
            state_d = S_ISSUE;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.combinations = acc_q;
          out_d.overflow     = ovf_q;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    n_q   <= n_d;
    k_q   <= k_d;
    m_q   <= m_d;
    i_q   <= i_d;
    acc_q <= acc_d;
    ovf_q <= ovf_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: hdl/bc_checker.sv
module bc_checker
  import bc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_word_i))
    else $error("input word dropped or changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a word is in progress");

  a_ovf_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.overflow |-> (&out_word_o.combinations))
    else $error("overflow without saturated result");

  a_never_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.combinations != '0))
    else $error("binomial coefficient of zero");

endmodule

bind binomial_coefficient bc_checker u_bc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_word_i  (in_word_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_word_o (out_word_o)
);

// File: bench/binomial_coefficient_checker.sv
`timescale 1ns / 1ps

module binomial_coefficient_checker
  import bc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_word_t   out_word_i,
  output int unsigned pending_o,
  output int unsigned mismatch_count_o
);

  out_word_t   expected_coeffs[$];
  int unsigned mismatches = 0;

  // The running value after step i is C(n, i+1), so each division is exact.
  // A quotient that needs more than 64 bits means the final value would too.
  function automatic out_word_t n_choose_k(in_word_t word);
    int           n;
    int           k;
    int           steps;
    logic [127:0] running;
    logic [127:0] quotient;
    out_word_t    coeff;
    n = $signed(word.item_count);
    k = $signed(word.chosen_count);
    coeff.combinations = 64'd1;
    coeff.overflow     = 1'b0;
    if (n < 0 || k < 0 || k > n) begin
      return coeff;
    end
    steps   = (k < n - k) ? k : n - k;
    running = 128'd1;
    for (int i = 0; i < steps; i++) begin
      quotient = (running * 128'(n - i)) / 128'(i + 1);
      if (quotient[127:64] != '0) begin
        coeff.combinations = '1;
        coeff.overflow     = 1'b1;
        return coeff;
      end
      running = quotient;
    end
    coeff.combinations = running[63:0];
    return coeff;
  endfunction

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_coeffs.size() == 0) begin
          $error("result word with none expected: combinations %0d, overflow %0b",
                 out_word_i.combinations, out_word_i.overflow);
          mismatches++;
        end else begin
          want = expected_coeffs.pop_front();
          if (out_word_i.combinations !== want.combinations) begin
            $error("combinations: expected %0d, actual %0d",
                   want.combinations, out_word_i.combinations);
            mismatches++;
          end
          if (out_word_i.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b",
                   want.overflow, out_word_i.overflow);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_coeffs.push_back(n_choose_k(in_word_i));
      end
      pending_o        <= expected_coeffs.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// File: bench/binomial_coefficient_tb.sv
`timescale 1ns / 1ps

module binomial_coefficient_tb;
  import bc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_word_t   out_word_o;
  int unsigned pending_words;
  int unsigned mismatch_count;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned send_idle_plan[4] = '{0, 75, 0, 19};
  int unsigned recv_stall_plan[4] = '{0, 0, 75, 19};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  binomial_coefficient u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  binomial_coefficient_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_word_i        (in_word_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_word_i       (out_word_o),
    .pending_o        (pending_words),
    .mismatch_count_o (mismatch_count)
  );

  task automatic send_counts(input int n, input int k);
    in_word_t word;
    word.item_count   = CountWidth'(n);
    word.chosen_count = CountWidth'(k);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= word;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Most words keep min(k, n-k) small or overflow early, so the run stays short.
  task automatic send_random_counts();
    int n;
    int k;
    int span;
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 20) begin
      n = $urandom;
      k = $urandom;
    end else if (pick < 35) begin
      case ($urandom_range(2, 0))
        0: begin
          n = -int'($urandom_range(32768, 1));
          k = $urandom;
        end
        1: begin
          n = $urandom_range(32767, 0);
          k = -int'($urandom_range(32768, 1));
        end
        default: begin
          n = $urandom_range(32766, 0);
          k = $urandom_range(32767, n + 1);
        end
      endcase
    end else if (pick < 75) begin
      n = $urandom_range(70, 0);
      k = $urandom_range(n, 0);
    end else begin
      n    = $urandom_range(32767, 0);
      span = $urandom_range(6, 0);
      if (span > n) begin
        span = n;
      end
      k = $urandom_range(1, 0) ? span : n - span;
    end
    send_counts(n, k);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_counts(0, 0);
    send_counts(-32768, -32768);
    send_counts(32767, 32767);
    send_counts(-1, 0);
    send_counts(5, -1);
    send_counts(3, 5);
    send_counts(32767, -32768);
    send_counts(-32768, 5);
    send_counts(100, -32768);
    send_counts(0, 32767);
    send_counts(1, 0);
    send_counts(1, 1);
    send_counts(10, 3);
    send_counts(10, 7);
    send_counts(32767, 1);
    send_counts(32767, 32766);
    send_counts(32767, 4);
    send_counts(32767, 5);
    send_counts(4000, 6);
    send_counts(66, 33);
    send_counts(67, 33);
    send_counts(67, 34);
    send_counts(68, 34);
    send_counts(32767, 16383);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  <= send_idle_plan[phase];
      recv_stall_pct <= recv_stall_plan[phase];
      repeat (49) send_random_counts();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (3500) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("binomial_coefficient verification clean");
    end else begin
      $display("binomial_coefficient verification failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("binomial_coefficient verification failed");
    $finish;
  end

endmodule

// File: sim.f
hdl/bc_pkg.sv
hdl/bc_mul_div.sv
hdl/binomial_coefficient.sv
hdl/bc_checker.sv
bench/binomial_coefficient_checker.sv
bench/binomial_coefficient_tb.sv
